/* rtl/compacting_handle_allocator_defines.svh */
// Assertion macros for the file that checks the allocator.
`ifndef COMPACTING_HANDLE_ALLOCATOR_DEFINES_SVH
`define COMPACTING_HANDLE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CHALC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/chalc_pkg.sv */
package chalc_pkg;

  localparam int WORD_BYTES = 8;
  localparam logic [16:0] BYTE_ROUND = 17'd7;
  localparam logic [16:0] BYTE_MASK  = 17'h7;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_NO_HANDLE = 3'd3;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd4;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       tbl_rd;
    logic       pos_rd;
    logic       words_ld;
    logic       scan_clr;
    logic       scan_inc;
    logic       alloc;
    logic       free_upd;
    logic       copy_start;
    logic       copy_run;
    logic       wr_word;
    logic       rd_word;
    logic       rd_ld;
    logic       set_st;
    logic [2:0] st_code;
    logic       load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       req_zero;
    logic       no_space;
    logic       h_bad;
    logic       scan_hit;
    logic       scan_last;
    logic       off_bad;
    logic       copy_needed;
    logic       copy_done;
    logic       out_slot;
  } sts_t;

endpackage

/* rtl/chalc_if.sv */
interface chalc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [14:0] request_bytes;
  logic [7:0]  handle;
  logic [11:0] word_offset;
  logic [63:0] write_data;
  modport source (output valid, operation, request_bytes, handle, word_offset, write_data,
                  input ready);
  modport sink (input valid, operation, request_bytes, handle, word_offset, write_data,
                output ready);
endinterface

interface chalc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  handle_given;
  logic [63:0] read_data;
  logic [14:0] free_bytes_left;
  modport source (output valid, status, handle_given, read_data, free_bytes_left,
                  input ready);
  modport sink (input valid, status, handle_given, read_data, free_bytes_left,
                output ready);
endinterface

interface chalc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] pool_bytes;
  modport source (output valid, pool_bytes, input ready);
  modport sink (input valid, pool_bytes, output ready);
endinterface

/* rtl/chalc_ram.sv */
module chalc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/chalc_ctrl.sv */
module chalc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  chalc_pkg::sts_t  sts_i,
  output chalc_pkg::cmd_t  cmd_o
);
  import chalc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_ALLOC  = 4'd3;
  localparam logic [3:0] S_POS    = 4'd4;
  localparam logic [3:0] S_WORDS  = 4'd5;
  localparam logic [3:0] S_EXEC   = 4'd6;
  localparam logic [3:0] S_RDATA  = 4'd7;
  localparam logic [3:0] S_COPY   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.op == OP_ALLOC) begin
          if (sts_i.req_zero) begin
            cmd_o.set_st = 1'b1; cmd_o.st_code = ST_ZERO_SIZE; state_d = S_DONE;
          end else if (sts_i.no_space) begin
            cmd_o.set_st = 1'b1; cmd_o.st_code = ST_NO_SPACE; state_d = S_DONE;
          end else begin
            cmd_o.scan_clr = 1'b1; state_d = S_SCAN;
          end
        end else if (sts_i.h_bad) begin
          cmd_o.set_st = 1'b1; cmd_o.st_code = ST_BAD_HANDLE; state_d = S_DONE;
        end else begin
          cmd_o.tbl_rd = 1'b1; state_d = S_POS;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_hit) begin
          state_d = S_ALLOC;
        end else if (sts_i.scan_last) begin
          cmd_o.set_st = 1'b1; cmd_o.st_code = ST_NO_HANDLE; state_d = S_DONE;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_ALLOC: begin
        cmd_o.alloc = 1'b1; state_d = S_DONE;
      end
      S_POS: begin
        cmd_o.pos_rd = 1'b1; state_d = S_WORDS;
      end
      S_WORDS: begin
        cmd_o.words_ld = 1'b1; state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.op == OP_FREE) begin
          cmd_o.free_upd = 1'b1;
          if (sts_i.copy_needed) begin
            cmd_o.copy_start = 1'b1; state_d = S_COPY;
          end else begin
            state_d = S_DONE;
          end
        end else if (sts_i.off_bad) begin
          cmd_o.set_st = 1'b1; cmd_o.st_code = ST_BAD_OFFSET; state_d = S_DONE;
        end else if (sts_i.op == OP_WRITE) begin
          cmd_o.wr_word = 1'b1; state_d = S_DONE;
        end else begin
          cmd_o.rd_word = 1'b1; state_d = S_RDATA;
        end
      end
      S_RDATA: begin
        cmd_o.rd_ld = 1'b1; state_d = S_DONE;
      end
      S_COPY: begin
        if (sts_i.copy_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.copy_run = 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.out_slot) begin
          cmd_o.load_out = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/chalc_dp.sv */
module chalc_dp #(
  parameter int POOL_WORDS   = 4096,
  parameter int HANDLE_COUNT = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  chalc_pkg::cmd_t cmd_i,
  output chalc_pkg::sts_t sts_o,
  input  logic [1:0]      operation_i,
  input  logic [14:0]     request_bytes_i,
  input  logic [7:0]      handle_i,
  input  logic [11:0]     word_offset_i,
  input  logic [63:0]     write_data_i,
  input  logic            cfg_valid_i,
  input  logic [15:0]     cfg_pool_bytes_i,
  input  logic            rsp_ready_i,
  output logic            rsp_valid_o,
  output logic [2:0]      status_o,
  output logic [7:0]      handle_given_o,
  output logic [63:0]     read_data_o,
  output logic [14:0]     free_bytes_left_o
);
  import chalc_pkg::*;

  localparam int AW  = $clog2(POOL_WORDS);
  localparam int PW  = AW + 1;
  localparam int BW  = $clog2(POOL_WORDS * WORD_BYTES + 1);
  localparam int CW  = (BW > 17) ? BW : 17;
  localparam int HW  = $clog2(HANDLE_COUNT);
  localparam logic [CW-1:0] CAP = CW'(POOL_WORDS * WORD_BYTES);

  // Usable pool bytes for a register value: aligned, capped, at least one word.
  function automatic logic [BW-1:0] eff_f(input logic [15:0] v);
    logic [CW-1:0] e;
    e = CW'({v[15:3], 3'b000});
    if (e > CAP) e = CAP;
    if (e < CW'(WORD_BYTES)) e = CW'(WORD_BYTES);
    return BW'(e);
  endfunction

  logic [BW-1:0]           e_q, f_q;
  logic [HANDLE_COUNT-1:0] valid_q;
  logic [1:0]              op_q;
  logic [14:0]             req_q;
  logic [7:0]              h_q;
  logic [11:0]             off_q;
  logic [63:0]             wdata_q;
  logic [PW-1:0]           end_q, words_q, rd_ptr_q, nxt_hdr_q, paddr_q;
  logic [AW-1:0]           pos_q;
  logic [HW-1:0]           scan_q;
  logic                    pipe_q, out_valid_q;
  logic [2:0]              st_q, out_st_q;
  logic [7:0]              given_q, out_given_q;
  logic [63:0]             rdata_q, out_rdata_q;
  logic [14:0]             out_free_q;

  logic          pool_we, pool_re, tbl_we;
  logic [AW-1:0] pool_waddr, pool_raddr, tbl_wdata, tbl_rdata;
  logic [63:0]   pool_wdata, pool_rdata;
  logic [HW-1:0] tbl_waddr;
  logic [16:0]   need;
  logic [PW-1:0] hdr_words, hdr_raw;
  logic [31:0]   idx32, owner;
  logic          issue, hdr_hit;

  chalc_ram #(.WIDTH(64), .DEPTH(POOL_WORDS)) u_pool (
    .clk_i, .we_i(pool_we), .waddr_i(pool_waddr), .wdata_i(pool_wdata),
    .re_i(pool_re), .raddr_i(pool_raddr), .rdata_o(pool_rdata)
  );

  chalc_ram #(.WIDTH(AW), .DEPTH(HANDLE_COUNT)) u_tbl (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_waddr), .wdata_i(tbl_wdata),
    .re_i(cmd_i.tbl_rd), .raddr_i(HW'(h_q)), .rdata_o(tbl_rdata)
  );

  assign need      = ((17'(req_q) + BYTE_ROUND) & ~BYTE_MASK) + 17'(WORD_BYTES);
  assign hdr_raw   = pool_rdata[3 +: PW];
  assign hdr_words = (hdr_raw == '0) ? PW'(1) : hdr_raw;
  assign owner     = pool_rdata[63:32];
  assign idx32     = 32'(pos_q) + 32'd1 + 32'(off_q);
  assign issue     = cmd_i.copy_run && (rd_ptr_q < end_q);
  assign hdr_hit   = pipe_q && (paddr_q == nxt_hdr_q);

  always_comb begin
    sts_o.op          = op_q;
    sts_o.req_zero    = (req_q == '0);
    sts_o.no_space    = CW'(f_q) < CW'(need);
    sts_o.h_bad       = (32'(h_q) >= 32'(HANDLE_COUNT)) || !valid_q[HW'(h_q)];
    sts_o.scan_hit    = !valid_q[scan_q];
    sts_o.scan_last   = (scan_q == HW'(HANDLE_COUNT - 1));
    sts_o.off_bad     = (32'(off_q) + 32'd1 >= 32'(words_q)) ||
                        (idx32 >= 32'(POOL_WORDS));
    sts_o.copy_needed = ((PW+1)'(pos_q) + (PW+1)'(words_q)) < (PW+1)'(end_q);
    sts_o.copy_done   = !(rd_ptr_q < end_q) && !pipe_q;
    sts_o.out_slot    = !out_valid_q || rsp_ready_i;
  end

  always_comb begin
    pool_we    = 1'b0;
    pool_waddr = AW'(end_q);
    pool_wdata = {32'(scan_q), 15'd0, need};
    priority if (cmd_i.alloc) begin
      pool_we = 1'b1;
    end else if (cmd_i.wr_word) begin
      pool_we    = 1'b1;
      pool_waddr = AW'(idx32);
      pool_wdata = wdata_q;
    end else if (pipe_q) begin
      pool_we    = 1'b1;
      pool_waddr = AW'(paddr_q - words_q);
      pool_wdata = pool_rdata;
    end
  end

  always_comb begin
    pool_re    = cmd_i.pos_rd || cmd_i.rd_word || issue;
    pool_raddr = AW'(rd_ptr_q);
    priority if (cmd_i.pos_rd) begin
      pool_raddr = tbl_rdata;
    end else if (cmd_i.rd_word) begin
      pool_raddr = AW'(idx32);
    end
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = scan_q;
    tbl_wdata = AW'(end_q);
    priority if (cmd_i.alloc) begin
      tbl_we = 1'b1;
    end else if (hdr_hit && (owner < 32'(HANDLE_COUNT))) begin
      tbl_we    = 1'b1;
      tbl_waddr = HW'(owner);
      tbl_wdata = AW'(paddr_q - words_q);
    end
  end

  // Control state: pool size, free count, handle valid bits, copy pipe, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q         <= eff_f(16'h8000);
      f_q         <= eff_f(16'h8000) - BW'(WORD_BYTES);
      valid_q     <= '0;
      pipe_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        e_q     <= eff_f(cfg_pool_bytes_i);
        f_q     <= eff_f(cfg_pool_bytes_i) - BW'(WORD_BYTES);
        valid_q <= '0;
      end else if (cmd_i.alloc) begin
        f_q             <= BW'(CW'(f_q) - CW'(need));
        valid_q[scan_q] <= 1'b1;
      end else if (cmd_i.free_upd) begin
        f_q                  <= BW'((PW+3)'(f_q) + (PW+3)'({words_q, 3'b000}));
        valid_q[HW'(h_q)]    <= 1'b0;
      end
      pipe_q <= issue;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= operation_i;
      req_q   <= request_bytes_i;
      h_q     <= handle_i;
      off_q   <= word_offset_i;
      wdata_q <= write_data_i;
      end_q   <= PW'((e_q - f_q) >> 3);
      st_q    <= ST_OK;
      given_q <= '0;
      rdata_q <= '0;
    end
    if (cmd_i.set_st) st_q <= cmd_i.st_code;
    if (cmd_i.scan_clr) scan_q <= '0;
    if (cmd_i.scan_inc) scan_q <= scan_q + HW'(1);
    if (cmd_i.alloc) given_q <= 8'(scan_q);
    if (cmd_i.pos_rd) pos_q <= tbl_rdata;
    if (cmd_i.words_ld) words_q <= hdr_words;
    if (cmd_i.rd_ld) rdata_q <= pool_rdata;
    if (cmd_i.copy_start) begin
      rd_ptr_q  <= PW'(pos_q) + words_q;
      nxt_hdr_q <= PW'(pos_q) + words_q;
    end
    if (issue) rd_ptr_q <= rd_ptr_q + PW'(1);
    paddr_q <= rd_ptr_q;
    if (hdr_hit) nxt_hdr_q <= paddr_q + hdr_words;
    if (cmd_i.load_out) begin
      out_st_q    <= st_q;
      out_given_q <= given_q;
      out_rdata_q <= rdata_q;
      out_free_q  <= 15'(f_q);
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign status_o          = out_st_q;
  assign handle_given_o    = out_given_q;
  assign read_data_o       = out_rdata_q;
  assign free_bytes_left_o = out_free_q;

endmodule

/* rtl/compacting_handle_allocator.sv */
// Compacting handle allocator over a pool of 64-bit words.
// Requests arrive as words on req_i (allocate, free, write word, read word); each gives
// exactly one response word on rsp_o with a status, the handle given, the read data and
// the free bytes left. cfg_i writes pool_bytes; it is always ready and reinitializes the
// allocator, so it must be written only while no request is in flight.
// One request is in work at a time. States from acceptance to response valid:
//   bad size, no space or unused handle: DECODE, then DONE;
//   allocate: DECODE, SCAN, ALLOC, DONE, where the lowest unused handle is found by
//   stepping through the valid bits one per cycle (up to HANDLE_COUNT);
//   write or bad offset: DECODE, POS, WORDS, EXEC, DONE; read: the same with RDATA
//   before DONE; free: the same as write when nothing follows the block, otherwise
//   COPY follows EXEC, in which every pool word behind the block slides down, since the
//   pool RAM moves one word per cycle (up to POOL_WORDS), and the copy pipeline drains.
// A finished response is held in an output register; the next request is accepted as
// soon as the response is loaded, and the controller waits at the end of that next
// request only while the receiver still stalls the previous response.
// Reset clears all handle valid bits and sets the free count from a pool
// size of 32768 bytes; no clearing pass over the pool RAM is needed.
module compacting_handle_allocator #(
  parameter int POOL_WORDS   = 4096,
  parameter int HANDLE_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chalc_req_if.sink   req_i,
  chalc_rsp_if.source rsp_o,
  chalc_cfg_if.sink   cfg_i
);
  import chalc_pkg::*;
`include "compacting_handle_allocator_defines.svh"

  cmd_t cmd;
  sts_t sts;

  // Configuration writes are taken in any cycle.
  assign cfg_i.ready = 1'b1;

  chalc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req_i.valid),
    .in_ready_o(req_i.ready),
    .sts_i(sts),
    .cmd_o(cmd)
  );

  chalc_dp #(.POOL_WORDS(POOL_WORDS), .HANDLE_COUNT(HANDLE_COUNT)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .sts_o(sts),
    .operation_i(req_i.operation),
    .request_bytes_i(req_i.request_bytes),
    .handle_i(req_i.handle),
    .word_offset_i(req_i.word_offset),
    .write_data_i(req_i.write_data),
    .cfg_valid_i(cfg_i.valid),
    .cfg_pool_bytes_i(cfg_i.pool_bytes),
    .rsp_ready_i(rsp_o.ready),
    .rsp_valid_o(rsp_o.valid),
    .status_o(rsp_o.status),
    .handle_given_o(rsp_o.handle_given),
    .read_data_o(rsp_o.read_data),
    .free_bytes_left_o(rsp_o.free_bytes_left)
  );

  // An accepted request keeps the input closed while it is in work.
  `CHALC_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready, !req_i.ready, "ready after accept")
  // Failed requests return neither a handle nor data.
  `CHALC_ASSERT_NOW(a_fail_clean, rsp_o.valid && (rsp_o.status != ST_OK), (rsp_o.handle_given == 8'd0) && (rsp_o.read_data == 64'd0), "failed response carries payload")
  // Free space always counts whole words.
  `CHALC_ASSERT_NOW(a_free_aligned, rsp_o.valid, rsp_o.free_bytes_left[2:0] == 3'd0, "free bytes not word aligned")
  // The copy pipeline only runs while the controller is moving words.
  `CHALC_ASSERT_NOW(a_copy_excl, cmd.copy_run, !cmd.alloc && !cmd.wr_word && !cmd.latch, "copy overlaps another command")

endmodule
